// ===== rtl/b64d_pkg.sv =====
// shared types, constants and character lookup for the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int BYTE_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int ACC_W       = 18;
    localparam int GROUP_W     = 24;
    localparam int CNT_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // group positions: characters already held in the current group
    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;
    localparam logic [1:0] POS_THREE = 2'd3;

    // byte slots within a decoded group
    localparam logic [1:0] SLOT_HI  = 2'd0;
    localparam logic [1:0] SLOT_MID = 2'd1;
    localparam logic [1:0] SLOT_LO  = 2'd2;

    typedef logic [SEXTET_W-1:0] sextet_t;

    // one decoded group handed from front to back
    typedef struct packed {
        logic [GROUP_W-1:0] word;   // bytes from the high end
        logic [CNT_W-1:0]   cnt;    // number of bytes, 1 to 3
        logic               last;   // final byte of the group closes the string
        logic               err;    // lone trailing character
    } grp_t;

    // map a character to its sextet, both alphabets plus '.' as 62 and ',' as 63, anything else is zero
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = SEXTET_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            s = SEXTET_W'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            s = SEXTET_W'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
            s = SEXTET_W'(62);
        end
        else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
            s = SEXTET_W'(63);
        end
        return s;
    endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// front end: character lookup, sextet packing and group classification
`timescale 1ns / 1ps

module b64d_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_ready,
    input  logic [7:0]       char_code,
    input  logic             is_final,
    output logic             grp_valid,
    input  logic             grp_ready,
    output b64d_pkg::grp_t   grp
);

    logic [1:0]                   pos_reg;
    logic [1:0]                   pos_next;
    logic [b64d_pkg::ACC_W-1:0]   acc_reg;
    logic [b64d_pkg::ACC_W-1:0]   acc_next;
    logic                         third_pad_reg;
    logic                         third_pad_next;

    b64d_pkg::sextet_t            sx;
    logic                         is_pad;
    logic                         accept;
    logic                         closes;

    // lookup
    assign sx     = b64d_pkg::sextet_of(char_code);
    assign is_pad = (char_code == b64d_pkg::PAD_CHAR);

    // a beat is taken only while the queue has room
    assign char_ready = grp_ready;
    assign accept     = char_valid && char_ready;
    assign closes     = is_final || (pos_reg == b64d_pkg::POS_THREE);
    assign grp_valid  = accept && closes;

    // classify the group that this beat closes
    always_comb
    begin
        grp.last = is_final;
        grp.err  = 1'b0;
        grp.word = {acc_reg, sx};
        grp.cnt  = 2'd3;
        if (is_final) begin
            unique case (pos_reg)
                b64d_pkg::POS_EMPTY:
                begin
                    grp.word = {sx, 2'b00, 16'h0000};
                    grp.cnt  = 2'd1;
                    grp.err  = 1'b1;
                end
                b64d_pkg::POS_ONE:
                begin
                    grp.word = {acc_reg[5:0], sx, 12'h000};
                    grp.cnt  = 2'd1;
                end
                b64d_pkg::POS_TWO:
                begin
                    grp.word = {acc_reg[11:0], sx, 6'h00};
                    grp.cnt  = is_pad ? 2'd1 : 2'd2;
                end
                b64d_pkg::POS_THREE:
                begin
                    if (is_pad) begin
                        grp.word = {acc_reg, 6'h00};
                        grp.cnt  = third_pad_reg ? 2'd1 : 2'd2;
                    end
                    else begin
                        grp.word = {acc_reg, sx};
                        grp.cnt  = 2'd3;
                    end
                end
                default:
                begin
                    grp.word = {acc_reg, sx};
                    grp.cnt  = 2'd3;
                end
            endcase
        end
    end

    // packing state
    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        if (accept) begin
            if (closes) begin
                pos_next       = b64d_pkg::POS_EMPTY;
                acc_next       = '0;
                third_pad_next = 1'b0;
            end
            else begin
                pos_next = pos_reg + 2'd1;
                acc_next = {acc_reg[b64d_pkg::ACC_W-b64d_pkg::SEXTET_W-1:0], sx};
                if (pos_reg == b64d_pkg::POS_TWO) begin
                    third_pad_next = is_pad;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= b64d_pkg::POS_EMPTY;
            acc_reg       <= '0;
            third_pad_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule

// ===== rtl/b64d_queue.sv =====
// short group queue between front and back
`timescale 1ns / 1ps

module b64d_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  b64d_pkg::grp_t   push_grp,
    output logic             pop_valid,
    input  logic             pop,
    output b64d_pkg::grp_t   pop_grp
);

    b64d_pkg::grp_t                  mem_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [b64d_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [b64d_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [b64d_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [b64d_pkg::QUEUE_CW-1:0]   count_reg;
    logic [b64d_pkg::QUEUE_CW-1:0]   count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != b64d_pkg::QUEUE_CW'(b64d_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_grp    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

// ===== rtl/b64d_back.sv =====
// back end: splits each group into bytes behind an output register
`timescale 1ns / 1ps

module b64d_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             grp_valid,
    output logic             grp_pop,
    input  b64d_pkg::grp_t   grp,
    output logic             byte_valid,
    input  logic             byte_ready,
    output logic [7:0]       data_byte,
    output logic             last_byte,
    output logic             tail_error
);

    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    logic         valid_reg;
    logic         valid_next;
    logic [7:0]   data_reg;
    logic [7:0]   data_next;
    logic         last_reg;
    logic         last_next;
    logic         err_reg;
    logic         err_next;
    logic         advance;
    logic         end_of_grp;
    logic [7:0]   sel_byte;

    assign advance    = grp_valid && (!valid_reg || byte_ready);
    assign end_of_grp = (idx_reg == grp.cnt - 2'd1);
    assign grp_pop    = advance && end_of_grp;

    // byte select within the group
    always_comb
    begin
        unique case (idx_reg)
            b64d_pkg::SLOT_HI:  sel_byte = grp.word[23:16];
            b64d_pkg::SLOT_MID: sel_byte = grp.word[15:8];
            b64d_pkg::SLOT_LO:  sel_byte = grp.word[7:0];
            default:            sel_byte = grp.word[7:0];
        endcase
    end

    // output register load and byte index
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !byte_ready;
        data_next  = data_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (advance) begin
            valid_next = 1'b1;
            data_next  = sel_byte;
            last_next  = grp.last && end_of_grp;
            err_next   = grp.err;
            idx_next   = end_of_grp ? b64d_pkg::SLOT_HI : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= b64d_pkg::SLOT_HI;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign byte_valid = valid_reg;
    assign data_byte  = data_reg;
    assign last_byte  = last_reg;
    assign tail_error = err_reg;

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: one character per beat in, one decoded byte per beat out.
// A closing character's group is written into the queue, then its first byte is loaded into the output register.
// Throughput: one character per cycle while the queue has room; the back end sends one byte per cycle unless stalled.
// A four-entry group queue lets the front keep taking characters while output stalls.
// Reset (rst_n low, asynchronous) clears the packing state, the queue and the output valid.
`timescale 1ns / 1ps

module base64_stream_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_ready,
    input  logic [7:0]   char_code,
    input  logic         is_final,
    output logic         byte_valid,
    input  logic         byte_ready,
    output logic [7:0]   data_byte,
    output logic         last_byte,
    output logic         tail_error
);

    logic             push_valid;
    logic             push_ready;
    b64d_pkg::grp_t   push_grp;
    logic             head_valid;
    logic             head_pop;
    b64d_pkg::grp_t   head_grp;

    // front end
    b64d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .is_final   (is_final),
        .grp_valid  (push_valid),
        .grp_ready  (push_ready),
        .grp        (push_grp)
    );

    // group queue
    b64d_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_grp   (push_grp),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_grp    (head_grp)
    );

    // back end
    b64d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp_valid  (head_valid),
        .grp_pop    (head_pop),
        .grp        (head_grp),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .tail_error (tail_error)
    );

endmodule

// ===== rtl/b64d_checker.sv =====
// port-level checks for the base64 stream decoder, bound to the top level
`timescale 1ns / 1ps

module b64d_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    input  logic         byte_ready,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic         tail_error
);

    // a tail error byte always closes the string
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && tail_error |-> last_byte)
        else $error("tail error byte without last_byte");

    // a lone trailing character carries its sextet in the high six bits
    a_err_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && tail_error |-> data_byte[1:0] == 2'b00)
        else $error("tail error byte has nonzero low bits");

    // nothing shows on the output right after reset
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !byte_valid)
        else $error("output beat right after reset");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(data_byte)
            && $stable(last_byte) && $stable(tail_error))
        else $error("output beat changed while stalled");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .tail_error (tail_error)
);
